@@ rtl/tdtm_pkg.sv @@
// Shared types and constants of the two-dimensional tape machine.
// Holds opcode characters, request codes, microcode layout and the microcode table.
// Depends on nothing.
package tdtm_pkg;

  // Request codes carried on the action field
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STEP  = 2'd2;

  // Span of the 6-bit row and column fields of a load request
  localparam int FIELD_SPAN = 64;

  // Headings
  localparam logic [1:0] HEAD_RIGHT = 2'd0;
  localparam logic [1:0] HEAD_UP    = 2'd1;
  localparam logic [1:0] HEAD_LEFT  = 2'd2;
  localparam logic [1:0] HEAD_DOWN  = 2'd3;

  // Opcode characters
  localparam logic [7:0] OP_INC     = 8'h2B;  // +
  localparam logic [7:0] OP_DEC     = 8'h2D;  // -
  localparam logic [7:0] OP_RIGHT   = 8'h7D;  // }
  localparam logic [7:0] OP_LEFT    = 8'h7B;  // {
  localparam logic [7:0] OP_TURN_L  = 8'h3C;  // <
  localparam logic [7:0] OP_TURN_R  = 8'h3E;  // >
  localparam logic [7:0] OP_TURN_U  = 8'h5E;  // ^
  localparam logic [7:0] OP_TURN_D  = 8'h76;  // v
  localparam logic [7:0] OP_SKIP    = 8'h21;  // !
  localparam logic [7:0] OP_MIRROR  = 8'h2F;  // /
  localparam logic [7:0] OP_BMIRROR = 8'h5C;  // backslash
  localparam logic [7:0] OP_IN      = 8'h2C;  // ,
  localparam logic [7:0] OP_OUT     = 8'h2E;  // .
  localparam logic [7:0] OP_START   = 8'h24;  // $
  localparam logic [7:0] OP_WALL    = 8'h23;  // #

  // Tape write address source
  typedef enum logic [1:0] {
    TSEL_CUR   = 2'd0,
    TSEL_RIGHT = 2'd1,
    TSEL_LEFT  = 2'd2
  } tsel_t;

  // Effect of one executed cell, from the execute unit to the datapath
  typedef struct packed {
    logic       stop;
    logic       fault;
    logic       move;
    logic       emit;
    logic       tape_we;
    tsel_t      tape_sel;
    logic [7:0] tape_wdata;
    logic       dp_inc;
    logic       dp_dec;
    logic       grow_r;
    logic       grow_l;
    logic [1:0] dir_next;
  } exec_ctl_t;

  // Microcode
  typedef logic [3:0] upc_t;

  localparam upc_t U_PCLR    = 4'd0;
  localparam upc_t U_IDLE    = 4'd1;
  localparam upc_t U_LOAD    = 4'd2;
  localparam upc_t U_START   = 4'd3;
  localparam upc_t U_TCLR    = 4'd4;
  localparam upc_t U_SCAN_RD = 4'd5;
  localparam upc_t U_SCAN_EV = 4'd6;
  localparam upc_t U_EXEC    = 4'd7;
  localparam upc_t U_REPORT  = 4'd8;
  localparam int   UROM_DEPTH = 9;

  typedef enum logic [3:0] {
    A_PCLR    = 4'd0,
    A_ACCEPT  = 4'd1,
    A_LOAD    = 4'd2,
    A_START   = 4'd3,
    A_TCLR    = 4'd4,
    A_SCAN_RD = 4'd5,
    A_SCAN_EV = 4'd6,
    A_EXEC    = 4'd7,
    A_REPORT  = 4'd8
  } uact_t;

  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_PCLR_MORE = 3'd1,
    C_TCLR_MORE = 3'd2,
    C_DISPATCH  = 3'd3,
    C_SCAN_MORE = 3'd4,
    C_OUT_BUSY  = 3'd5
  } ucond_t;

  // Next step is tgt when the condition holds, else alt
  typedef struct packed {
    uact_t  act;
    ucond_t cond;
    upc_t   tgt;
    upc_t   alt;
  } ucw_t;

  function automatic ucw_t ucode(input upc_t addr);
    ucw_t w;
    case (addr)
      U_PCLR:    w = '{A_PCLR,    C_PCLR_MORE, U_PCLR,    U_IDLE};
      U_IDLE:    w = '{A_ACCEPT,  C_DISPATCH,  U_IDLE,    U_IDLE};
      U_LOAD:    w = '{A_LOAD,    C_ALWAYS,    U_REPORT,  U_REPORT};
      U_START:   w = '{A_START,   C_ALWAYS,    U_TCLR,    U_TCLR};
      U_TCLR:    w = '{A_TCLR,    C_TCLR_MORE, U_TCLR,    U_SCAN_RD};
      U_SCAN_RD: w = '{A_SCAN_RD, C_ALWAYS,    U_SCAN_EV, U_SCAN_EV};
      U_SCAN_EV: w = '{A_SCAN_EV, C_SCAN_MORE, U_SCAN_RD, U_REPORT};
      U_EXEC:    w = '{A_EXEC,    C_ALWAYS,    U_REPORT,  U_REPORT};
      U_REPORT:  w = '{A_REPORT,  C_OUT_BUSY,  U_REPORT,  U_IDLE};
      default:   w = '{A_REPORT,  C_ALWAYS,    U_IDLE,    U_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/tdtm_exec.sv @@
// Execute unit: decodes one program cell and works out its effect on tape,
// data pointer, heading and instruction position. Depends on tdtm_pkg.
module tdtm_exec #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64,
  parameter int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1,
  parameter int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1
) (
  input  logic                 cell_present,
  input  logic [7:0]           cell_code,
  input  logic [7:0]           cell_val,
  input  logic [7:0]           in_byte,
  input  logic [1:0]           dir,
  input  logic                 dp_at_end,
  input  logic                 dp_at_zero,
  input  logic                 tape_full,
  input  logic [RW-1:0]        ip_row,
  input  logic [CW-1:0]        ip_col,
  output tdtm_pkg::exec_ctl_t  ctl,
  output logic [RW-1:0]        row_next,
  output logic [CW-1:0]        col_next
);
  import tdtm_pkg::*;

  localparam logic [RW:0] ROW_MAX = (RW+1)'(GRID_ROWS - 1);
  localparam logic [CW:0] COL_MAX = (CW+1)'(GRID_COLS - 1);

  exec_ctl_t   dec;
  logic        halt;
  logic        gfail;
  logic        nz;
  logic        move_ok;
  logic [RW:0] kr;
  logic [CW:0] kc;
  logic [RW:0] r_sum;
  logic [RW:0] r_dif;
  logic [CW:0] c_sum;
  logic [CW:0] c_dif;

  assign halt = !cell_present || (cell_code == OP_WALL);
  assign nz   = (cell_val != 8'd0);

  always_comb begin
    dec          = '0;
    dec.dir_next = dir;
    dec.tape_sel = TSEL_CUR;
    gfail        = 1'b0;
    case (cell_code)
      OP_INC: begin
        dec.tape_we    = 1'b1;
        dec.tape_wdata = cell_val + 8'd1;
      end
      OP_DEC: begin
        dec.tape_we    = 1'b1;
        dec.tape_wdata = cell_val - 8'd1;
      end
      OP_IN: begin
        dec.tape_we    = 1'b1;
        dec.tape_wdata = in_byte;
      end
      OP_RIGHT: begin
        if (!dp_at_end) begin
          dec.dp_inc = 1'b1;
        end else if (!tape_full) begin
          // grow at the far end and step onto the new zero cell
          dec.dp_inc   = 1'b1;
          dec.grow_r   = 1'b1;
          dec.tape_we  = 1'b1;
          dec.tape_sel = TSEL_RIGHT;
        end else begin
          gfail = 1'b1;
        end
      end
      OP_LEFT: begin
        if (!dp_at_zero) begin
          dec.dp_dec = 1'b1;
        end else if (!tape_full) begin
          // prepend a zero cell; pointer stays at offset zero
          dec.grow_l   = 1'b1;
          dec.tape_we  = 1'b1;
          dec.tape_sel = TSEL_LEFT;
        end else begin
          gfail = 1'b1;
        end
      end
      OP_MIRROR:  dec.dir_next = dir ^ 2'b01;
      OP_BMIRROR: dec.dir_next = ~dir;  // three minus heading
      OP_TURN_L:  if (nz) dec.dir_next = HEAD_LEFT;
      OP_TURN_R:  if (nz) dec.dir_next = HEAD_RIGHT;
      OP_TURN_U:  if (nz) dec.dir_next = HEAD_UP;
      OP_TURN_D:  if (nz) dec.dir_next = HEAD_DOWN;
      OP_OUT:     dec.emit = 1'b1;
      default: ;
    endcase
  end

  // advance one cell, or two for a skip, along the new heading
  assign kr    = (cell_code == OP_SKIP) ? (RW+1)'(2) : (RW+1)'(1);
  assign kc    = (cell_code == OP_SKIP) ? (CW+1)'(2) : (CW+1)'(1);
  assign r_sum = {1'b0, ip_row} + kr;
  assign r_dif = {1'b0, ip_row} - kr;
  assign c_sum = {1'b0, ip_col} + kc;
  assign c_dif = {1'b0, ip_col} - kc;

  always_comb begin
    move_ok  = 1'b0;
    row_next = ip_row;
    col_next = ip_col;
    case (dec.dir_next)
      HEAD_RIGHT: begin
        move_ok  = (c_sum <= COL_MAX);
        col_next = c_sum[CW-1:0];
      end
      HEAD_UP: begin
        move_ok  = ({1'b0, ip_row} >= kr);
        row_next = r_dif[RW-1:0];
      end
      HEAD_LEFT: begin
        move_ok  = ({1'b0, ip_col} >= kc);
        col_next = c_dif[CW-1:0];
      end
      default: begin
        move_ok  = (r_sum <= ROW_MAX);
        row_next = r_sum[RW-1:0];
      end
    endcase
  end

  always_comb begin
    ctl = dec;
    if (halt) begin
      ctl          = '0;
      ctl.dir_next = dir;
      ctl.stop     = 1'b1;
    end else if (gfail) begin
      ctl.stop  = 1'b1;
      ctl.fault = 1'b1;
    end else if (move_ok) begin
      ctl.move = 1'b1;
    end else begin
      // leaving the grid: effect stands, position holds
      ctl.stop = 1'b1;
    end
  end

endmodule

@@ rtl/two_dim_tape_machine_step_core.sv @@
// Top level of the two-dimensional tape machine: microcode sequencer, program
// and tape memories, datapath registers. Depends on tdtm_pkg and tdtm_exec.
//
// Usage: one request on req_valid/req_stall carries action, cell_row,
// cell_col, cell_byte and in_byte; every request yields exactly one response
// on rsp_valid/rsp_stall with out_valid, out_byte, halted, fault, pos_row,
// pos_col and heading. The core handles one request at a time.
//   load cell:   accept, write the program cell, report.
//   step:        accept and fetch, execute, report; the fetch is registered by the
//                synchronous read of the program and tape memories.
//   start run:   reset the datapath, clear INITIAL_CELLS tape cells (at most TAPE_CELLS),
//                scan program cells for the start mark (read, then evaluate), report.
//   other code / step while halted: accept, report.
// After reset the program memory is cleared, one entry a cycle, all
// 2**(row bits + column bits) entries (4096 with the default grid); no
// request is taken meanwhile. Reset leaves the machine halted.
// The response sits in an output register; while rsp_stall is high it holds,
// and the core takes the next request but waits in its report step until
// the previous response has been taken.
module two_dim_tape_machine_step_core #(
  parameter int GRID_ROWS     = 64,
  parameter int GRID_COLS     = 64,
  parameter int TAPE_CELLS    = 256,
  parameter int INITIAL_CELLS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] action,
  input  logic [5:0] cell_row,
  input  logic [5:0] cell_col,
  input  logic [7:0] cell_byte,
  input  logic [7:0] in_byte,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       halted,
  output logic       fault,
  output logic [5:0] pos_row,
  output logic [5:0] pos_col,
  output logic [1:0] heading
);
  import tdtm_pkg::*;

  localparam int RW        = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CW        = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int PROG_ROWS = (GRID_ROWS < FIELD_SPAN) ? GRID_ROWS : FIELD_SPAN;
  localparam int PROG_COLS = (GRID_COLS < FIELD_SPAN) ? GRID_COLS : FIELD_SPAN;
  localparam int PRW       = (PROG_ROWS > 1) ? $clog2(PROG_ROWS) : 1;
  localparam int PCW       = (PROG_COLS > 1) ? $clog2(PROG_COLS) : 1;
  localparam int PAW       = PRW + PCW;
  localparam int PDEPTH    = 1 << PAW;
  localparam int TW        = $clog2(TAPE_CELLS);
  localparam int LW        = $clog2(TAPE_CELLS + 1);
  localparam int INIT_LEN  = (INITIAL_CELLS < TAPE_CELLS) ? INITIAL_CELLS : TAPE_CELLS;
  localparam int CNTW      = (PAW > TW) ? PAW : TW;

  // sequencer
  upc_t upc;
  upc_t upc_next;
  ucw_t uw;
  logic take;

  // request payload
  logic [5:0] row_q;
  logic [5:0] col_q;
  logic [7:0] byte_q;
  logic [7:0] inb_q;

  // datapath registers
  logic [CNTW-1:0] cnt;
  logic [RW-1:0]   sr;
  logic [CW-1:0]   sc;
  logic [RW-1:0]   ip_row;
  logic [CW-1:0]   ip_col;
  logic [1:0]      dir;
  logic            stopped;
  logic            overflow;
  logic [TW-1:0]   base;
  logic [LW-1:0]   len;
  logic [TW-1:0]   dp;
  logic            emit;
  logic [7:0]      emit_byte;

  // memories
  logic [8:0] pmem [PDEPTH];
  logic [8:0] pmem_q;
  logic       p_ok_q;
  logic [7:0] tmem [TAPE_CELLS];
  logic [7:0] tmem_q;

  logic [RW-1:0]  rsel;
  logic [CW-1:0]  csel;
  logic           p_rok;
  logic [PAW-1:0] p_raddr;
  logic           p_we;
  logic [PAW-1:0] p_waddr;
  logic [8:0]     p_wdata;
  logic           t_we;
  logic [TW-1:0]  t_waddr;
  logic [7:0]     t_wdata;

  logic [TW:0]   cur_sum;
  logic [TW:0]   end_sum;
  logic [TW-1:0] phys_cur;
  logic [TW-1:0] phys_end;
  logic [TW-1:0] base_dec;
  logic          dp_at_end;
  logic          dp_at_zero;
  logic          tape_full;

  logic          pclr_more;
  logic          tclr_more;
  logic          scan_run;
  logic          scan_more;
  logic          scan_found;
  logic          row_adv;
  logic [RW-1:0] sr_n;
  logic [CW-1:0] sc_n;
  logic          out_load;

  exec_ctl_t     ctl;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_next;

  assign uw        = ucode(upc);
  assign req_stall = (uw.act != A_ACCEPT);
  assign out_load  = (uw.act == A_REPORT) && !(rsp_valid && rsp_stall);

  // tape addressing inside the circular store
  assign cur_sum  = {1'b0, base} + {1'b0, dp};
  assign end_sum  = {1'b0, base} + (TW+1)'(len);
  assign phys_cur = (cur_sum >= (TW+1)'(TAPE_CELLS)) ?
                    TW'(cur_sum - (TW+1)'(TAPE_CELLS)) : cur_sum[TW-1:0];
  assign phys_end = (end_sum >= (TW+1)'(TAPE_CELLS)) ?
                    TW'(end_sum - (TW+1)'(TAPE_CELLS)) : end_sum[TW-1:0];
  assign base_dec = (base == '0) ? TW'(TAPE_CELLS - 1) : base - TW'(1);

  assign dp_at_end  = (LW'(dp) + LW'(1)) >= len;
  assign dp_at_zero = (dp == '0);
  assign tape_full  = (len == LW'(TAPE_CELLS));

  assign pclr_more = (cnt[PAW-1:0] != {PAW{1'b1}});
  assign tclr_more = (cnt[TW-1:0] != TW'(INIT_LEN - 1));

  // program memory ports
  always_comb begin
    if (uw.act == A_SCAN_RD) begin
      rsel = sr;
      csel = sc;
    end else begin
      rsel = ip_row;
      csel = ip_col;
    end
  end

  assign p_rok   = (rsel < PROG_ROWS) && (csel < PROG_COLS);
  assign p_raddr = {rsel[PRW-1:0], csel[PCW-1:0]};

  always_comb begin
    if (uw.act == A_PCLR) begin
      p_we    = 1'b1;
      p_waddr = cnt[PAW-1:0];
      p_wdata = 9'd0;
    end else begin
      p_we    = (uw.act == A_LOAD) && (row_q < PROG_ROWS) && (col_q < PROG_COLS);
      p_waddr = {row_q[PRW-1:0], col_q[PCW-1:0]};
      p_wdata = {1'b1, byte_q};
    end
  end

  // tape memory write port
  always_comb begin
    if (uw.act == A_TCLR) begin
      t_we    = 1'b1;
      t_waddr = cnt[TW-1:0];
      t_wdata = 8'd0;
    end else begin
      t_we    = (uw.act == A_EXEC) && ctl.tape_we;
      t_wdata = ctl.tape_wdata;
      case (ctl.tape_sel)
        TSEL_RIGHT: t_waddr = phys_end;
        TSEL_LEFT:  t_waddr = base_dec;
        default:    t_waddr = phys_cur;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    pmem_q <= pmem[p_raddr];
    p_ok_q <= p_rok;
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_waddr] <= t_wdata;
    end
    tmem_q <= tmem[phys_cur];
  end

  // start-mark scan over rows until one that opens with a blank or wall, each row up to its first blank or wall
  assign scan_run = p_ok_q && pmem_q[8] && (pmem_q[7:0] != OP_WALL);

  always_comb begin
    scan_more  = 1'b1;
    scan_found = 1'b0;
    row_adv    = 1'b0;
    sr_n       = sr;
    sc_n       = sc;
    if (!scan_run) begin
      if (sc == '0) begin
        scan_more = 1'b0;
      end else begin
        row_adv = 1'b1;
      end
    end else if (pmem_q[7:0] == OP_START) begin
      scan_found = 1'b1;
      scan_more  = 1'b0;
    end else if (sc == CW'(GRID_COLS - 1)) begin
      row_adv = 1'b1;
    end else begin
      sc_n = sc + CW'(1);
    end
    if (row_adv) begin
      if (sr == RW'(GRID_ROWS - 1)) begin
        scan_more = 1'b0;
      end else begin
        sr_n = sr + RW'(1);
        sc_n = '0;
      end
    end
  end

  tdtm_exec #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .RW        (RW),
    .CW        (CW)
  ) u_exec (
    .cell_present (p_ok_q & pmem_q[8]),
    .cell_code    (pmem_q[7:0]),
    .cell_val     (tmem_q),
    .in_byte      (inb_q),
    .dir          (dir),
    .dp_at_end    (dp_at_end),
    .dp_at_zero   (dp_at_zero),
    .tape_full    (tape_full),
    .ip_row       (ip_row),
    .ip_col       (ip_col),
    .ctl          (ctl),
    .row_next     (row_next),
    .col_next     (col_next)
  );

  // next step
  always_comb begin
    case (uw.cond)
      C_PCLR_MORE: take = pclr_more;
      C_TCLR_MORE: take = tclr_more;
      C_SCAN_MORE: take = scan_more;
      C_OUT_BUSY:  take = rsp_valid && rsp_stall;
      default:     take = 1'b1;
    endcase
    upc_next = take ? uw.tgt : uw.alt;
    if (uw.cond == C_DISPATCH) begin
      if (!req_valid) begin
        upc_next = U_IDLE;
      end else begin
        case (action)
          ACT_LOAD:  upc_next = U_LOAD;
          ACT_START: upc_next = U_START;
          ACT_STEP:  upc_next = stopped ? U_REPORT : U_EXEC;
          default:   upc_next = U_REPORT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= U_PCLR;
      cnt       <= '0;
      rsp_valid <= 1'b0;
      stopped   <= 1'b1;
      overflow  <= 1'b0;
      dir       <= HEAD_RIGHT;
      ip_row    <= '0;
      ip_col    <= '0;
      sr        <= '0;
      sc        <= '0;
      base      <= '0;
      len       <= LW'(INIT_LEN);
      dp        <= '0;
      emit      <= 1'b0;
    end else begin
      upc       <= upc_next;
      rsp_valid <= out_load || (rsp_valid && rsp_stall);
      case (uw.act)
        A_PCLR, A_TCLR: cnt <= cnt + CNTW'(1);
        A_ACCEPT: begin
          if (req_valid) begin
            emit <= 1'b0;
          end
        end
        A_START: begin
          base     <= '0;
          len      <= LW'(INIT_LEN);
          dp       <= '0;
          dir      <= HEAD_RIGHT;
          overflow <= 1'b0;
          stopped  <= 1'b0;
          ip_row   <= '0;
          ip_col   <= '0;
          sr       <= '0;
          sc       <= '0;
          cnt      <= '0;
        end
        A_SCAN_EV: begin
          sr <= sr_n;
          sc <= sc_n;
          if (scan_found) begin
            ip_row <= sr;
            ip_col <= sc;
          end
        end
        A_EXEC: begin
          dir  <= ctl.dir_next;
          emit <= ctl.emit;
          if (ctl.stop) begin
            stopped <= 1'b1;
          end
          if (ctl.fault) begin
            overflow <= 1'b1;
          end
          if (ctl.move) begin
            ip_row <= row_next;
            ip_col <= col_next;
          end
          if (ctl.dp_inc) begin
            dp <= dp + TW'(1);
          end
          if (ctl.dp_dec) begin
            dp <= dp - TW'(1);
          end
          if (ctl.grow_r || ctl.grow_l) begin
            len <= len + LW'(1);
          end
          if (ctl.grow_l) begin
            base <= base_dec;
          end
        end
        default: ;
      endcase
    end
  end

  // request payload and response registers
  always_ff @(posedge clk) begin
    if (uw.act == A_ACCEPT && req_valid) begin
      row_q  <= cell_row;
      col_q  <= cell_col;
      byte_q <= cell_byte;
      inb_q  <= in_byte;
    end
    if (uw.act == A_EXEC) begin
      emit_byte <= tmem_q;
    end
    if (out_load) begin
      out_valid <= emit;
      out_byte  <= emit ? emit_byte : 8'd0;
      halted    <= stopped;
      fault     <= overflow;
      pos_row   <= 6'(ip_row);
      pos_col   <= 6'(ip_col);
      heading   <= dir;
    end
  end

`ifndef SYNTH
  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    overflow |-> stopped)
    else $error("tape fault without halt");

  a_dp_in_tape: assert property (@(posedge clk) disable iff (rst)
    (LW'(dp) < len) && (len <= LW'(TAPE_CELLS)))
    else $error("data pointer or tape length out of range");

  a_upc_range: assert property (@(posedge clk) disable iff (rst)
    upc < upc_t'(UROM_DEPTH))
    else $error("micro step outside the control table");

  a_rsp_from_report: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(upc == U_REPORT))
    else $error("response raised outside the report step");
`endif

endmodule

@@ tb/tb_two_dim_tape_machine_step_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for two_dim_tape_machine_step_core: loads grid programs, starts runs,
// steps them and checks every response against a behavioral copy of the machine.
// Depends on tdtm_pkg and the core RTL.
module tb_two_dim_tape_machine_step_core;
  import tdtm_pkg::*;

  localparam int GRID_ROWS      = 64;
  localparam int GRID_COLS      = 64;
  localparam int TAPE_CELLS     = 256;
  localparam int INIT_CELLS     = 128;
  localparam int INIT_LEN       = (INIT_CELLS < TAPE_CELLS) ? INIT_CELLS : TAPE_CELLS;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS   = 750;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 20;

  typedef struct packed {
    logic       hold_for_drain;
    logic [1:0] action;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] cbyte;
    logic [7:0] ibyte;
  } tape_req_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       halted;
    logic       fault;
    logic [5:0] pos_row;
    logic [5:0] pos_col;
    logic [1:0] heading;
  } tape_status_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  tape_req_t  cur_req   = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       halted;
  logic       fault;
  logic [5:0] pos_row;
  logic [5:0] pos_col;
  logic [1:0] heading;

  // Behavioral copy of the machine
  logic [8:0]  grid_mem [GRID_ROWS*GRID_COLS];
  logic [7:0]  tape_mem [TAPE_CELLS];
  int unsigned tape_origin;
  int unsigned tape_span;
  int unsigned tape_ptr;
  int unsigned ip_row_m;
  int unsigned ip_col_m;
  logic [1:0]  dir_m;
  bit          stopped_m;
  bit          overflow_m;

  tape_req_t    pending_req_q[$];
  tape_status_t expected_status_q[$];

  int error_count = 0;
  int rsp_count   = 0;
  int idle_cycles = 0;
  int send_gap    = 0;
  int recv_hold   = 0;
  bit send_burst  = 1'b0;
  bit recv_burst  = 1'b0;
  int gap_now;
  int hold_now;
  tape_status_t got_status;
  tape_status_t want_status;

  two_dim_tape_machine_step_core #(
    .GRID_ROWS    (GRID_ROWS),
    .GRID_COLS    (GRID_COLS),
    .TAPE_CELLS   (TAPE_CELLS),
    .INITIAL_CELLS(INIT_CELLS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .action   (cur_req.action),
    .cell_row (cur_req.row),
    .cell_col (cur_req.col),
    .cell_byte(cur_req.cbyte),
    .in_byte  (cur_req.ibyte),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .out_valid(out_valid),
    .out_byte (out_byte),
    .halted   (halted),
    .fault    (fault),
    .pos_row  (pos_row),
    .pos_col  (pos_col),
    .heading  (heading)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bit cell_runs(int unsigned r, int unsigned c);
    logic [8:0] v;
    v = grid_mem[r*GRID_COLS + c];
    return v[8] && (v[7:0] != OP_WALL);
  endfunction

  // Apply one request to the machine copy and return the status it reports
  function automatic tape_status_t predict_status(tape_req_t rq);
    tape_status_t st;
    logic [7:0]   op;
    int unsigned  p, nr, nc, moves, i, r, c;
    bit           grow_fail, blocked, scanning;
    st = '0;
    case (rq.action)
      ACT_LOAD: begin
        grid_mem[int'(rq.row)*GRID_COLS + int'(rq.col)] = {1'b1, rq.cbyte};
      end
      ACT_START: begin
        for (i = 0; i < TAPE_CELLS; i++) tape_mem[i] = '0;
        tape_origin = 0;
        tape_span   = INIT_LEN;
        tape_ptr    = 0;
        dir_m       = HEAD_RIGHT;
        overflow_m  = 1'b0;
        stopped_m   = 1'b0;
        ip_row_m    = 0;
        ip_col_m    = 0;
        scanning    = 1'b1;
        // scan rows until one that opens absent or walled; each row up to its first gap
        for (r = 0; r < GRID_ROWS && scanning; r++) begin
          if (!cell_runs(r, 0)) begin
            scanning = 1'b0;
          end else begin
            for (c = 0; c < GRID_COLS && scanning && cell_runs(r, c); c++) begin
              if (grid_mem[r*GRID_COLS + c][7:0] == OP_START) begin
                ip_row_m = r;
                ip_col_m = c;
                scanning = 1'b0;
              end
            end
          end
        end
      end
      ACT_STEP: begin
        if (!stopped_m) begin
          if (!cell_runs(ip_row_m, ip_col_m)) begin
            stopped_m = 1'b1;
          end else begin
            op = grid_mem[ip_row_m*GRID_COLS + ip_col_m][7:0];
            p = (tape_origin + tape_ptr) % TAPE_CELLS;
            grow_fail = 1'b0;
            case (op)
              OP_INC: tape_mem[p] = tape_mem[p] + 8'd1;
              OP_DEC: tape_mem[p] = tape_mem[p] - 8'd1;
              OP_RIGHT: begin
                if (tape_ptr + 1 < tape_span) begin
                  tape_ptr++;
                end else if (tape_span < TAPE_CELLS) begin
                  tape_mem[(tape_origin + tape_span) % TAPE_CELLS] = '0;
                  tape_span++;
                  tape_ptr++;
                end else begin
                  grow_fail = 1'b1;
                end
              end
              OP_LEFT: begin
                if (tape_ptr > 0) begin
                  tape_ptr--;
                end else if (tape_span < TAPE_CELLS) begin
                  tape_origin = (tape_origin + TAPE_CELLS - 1) % TAPE_CELLS;
                  tape_mem[tape_origin] = '0;
                  tape_span++;
                end else begin
                  grow_fail = 1'b1;
                end
              end
              OP_MIRROR:  dir_m = dir_m ^ 2'd1;
              OP_BMIRROR: dir_m = 2'd3 - dir_m;
              OP_TURN_L:  if (tape_mem[p] != 0) dir_m = HEAD_LEFT;
              OP_TURN_R:  if (tape_mem[p] != 0) dir_m = HEAD_RIGHT;
              OP_TURN_U:  if (tape_mem[p] != 0) dir_m = HEAD_UP;
              OP_TURN_D:  if (tape_mem[p] != 0) dir_m = HEAD_DOWN;
              OP_IN:      tape_mem[p] = rq.ibyte;
              OP_OUT: begin
                st.out_valid = 1'b1;
                st.out_byte  = tape_mem[p];
              end
              default: ;
            endcase
            if (grow_fail) begin
              overflow_m = 1'b1;
              stopped_m  = 1'b1;
            end else begin
              moves = (op == OP_SKIP) ? 2 : 1;
              nr = ip_row_m;
              nc = ip_col_m;
              blocked = 1'b0;
              for (i = 0; i < moves && !blocked; i++) begin
                case (dir_m)
                  HEAD_RIGHT: if (nc + 1 >= GRID_COLS) blocked = 1'b1; else nc++;
                  HEAD_UP:    if (nr == 0) blocked = 1'b1; else nr--;
                  HEAD_LEFT:  if (nc == 0) blocked = 1'b1; else nc--;
                  default:    if (nr + 1 >= GRID_ROWS) blocked = 1'b1; else nr++;
                endcase
              end
              // stay on the executed cell when the move would leave the grid
              if (blocked) begin
                stopped_m = 1'b1;
              end else begin
                ip_row_m = nr;
                ip_col_m = nc;
              end
            end
          end
        end
      end
      default: ;
    endcase
    st.halted  = stopped_m;
    st.fault   = overflow_m;
    st.pos_row = ip_row_m[5:0];
    st.pos_col = ip_col_m[5:0];
    st.heading = dir_m;
    return st;
  endfunction

  function automatic int pick_gap(bit burst);
    int roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(0, 17))
      0:  return OP_INC;
      1:  return OP_DEC;
      2:  return OP_RIGHT;
      3:  return OP_LEFT;
      4:  return OP_TURN_L;
      5:  return OP_TURN_R;
      6:  return OP_TURN_U;
      7:  return OP_TURN_D;
      8:  return OP_SKIP;
      9:  return OP_MIRROR;
      10: return OP_BMIRROR;
      11: return OP_IN;
      12: return OP_OUT;
      13: return OP_START;
      14: return OP_WALL;
      15: return OP_INC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Opcodes that never turn, for straight runs to the grid edge
  function automatic logic [7:0] pick_straight();
    case ($urandom_range(0, 9))
      0: return OP_INC;
      1: return OP_DEC;
      2: return OP_SKIP;
      3: return OP_OUT;
      4: return OP_IN;
      5: return OP_RIGHT;
      6: return OP_LEFT;
      7: return 8'h00;
      8: return 8'hFF;
      default: return OP_INC;
    endcase
  endfunction

  task automatic push_req(int act, int r, int c, int b, int ib);
    tape_req_t rq;
    rq.hold_for_drain = 1'b0;
    rq.action = act[1:0];
    rq.row    = r[5:0];
    rq.col    = c[5:0];
    rq.cbyte  = b[7:0];
    rq.ibyte  = ib[7:0];
    pending_req_q.push_back(rq);
  endtask

  task automatic load_cell(int r, int c, logic [7:0] b);
    push_req(ACT_LOAD, r, c, b, $urandom_range(0, 255));
  endtask

  task automatic push_ctl(logic [1:0] act, int n);
    for (int i = 0; i < n; i++)
      push_req(act, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255),
               $urandom_range(0, 255));
  endtask

  initial begin : stimulus
    int k, h, w, r, c, n, i, first, directed_n;
    logic [7:0] run_op;

    for (i = 0; i < GRID_ROWS*GRID_COLS; i++) grid_mem[i] = '0;
    for (i = 0; i < TAPE_CELLS; i++) tape_mem[i] = '0;
    tape_origin = 0;
    tape_span   = INIT_LEN;
    tape_ptr    = 0;
    ip_row_m    = 0;
    ip_col_m    = 0;
    dir_m       = HEAD_RIGHT;
    stopped_m   = 1'b1;
    overflow_m  = 1'b0;

    // Directed: halted after reset, unused code, empty grid, walls, every I/O opcode
    push_ctl(ACT_STEP, 1);
    push_ctl(ACT_UNUSED, 1);
    push_ctl(ACT_START, 1);
    push_ctl(ACT_STEP, 1);
    load_cell(63, 63, 8'hFF);
    load_cell(0, 63, 8'h00);
    load_cell(0, 0, OP_WALL);
    push_ctl(ACT_START, 1);
    push_ctl(ACT_STEP, 1);
    load_cell(0, 0, OP_START);
    load_cell(0, 1, OP_IN);
    load_cell(0, 2, OP_OUT);
    load_cell(0, 3, OP_DEC);
    load_cell(0, 4, OP_OUT);
    load_cell(0, 5, OP_SKIP);
    load_cell(0, 6, OP_WALL);
    load_cell(0, 7, OP_TURN_U);
    push_ctl(ACT_START, 1);
    push_req(ACT_STEP, 0, 0, 0, 0);
    push_req(ACT_STEP, 63, 63, 255, 255);
    push_ctl(ACT_STEP, 6);
    directed_n = pending_req_q.size();

    k = 0;
    while (pending_req_q.size() < directed_n + RANDOM_ITEMS || k < 8) begin
      first = pending_req_q.size();
      case (k)
        1, 3: begin
          // closed loop that moves the data pointer every lap, growing the tape until it is full
          run_op = (k == 1) ? OP_RIGHT : OP_LEFT;
          w = $urandom_range(10, 20);
          load_cell(0, 0, OP_TURN_R);
          load_cell(0, 1, OP_START);
          for (c = 2; c <= w - 3; c++) load_cell(0, c, run_op);
          load_cell(0, w - 2, OP_INC);
          load_cell(0, w - 1, OP_TURN_D);
          load_cell(1, 0, OP_TURN_U);
          load_cell(1, 1, OP_INC);
          for (c = 2; c <= w - 2; c++) load_cell(1, c, run_op);
          load_cell(1, w - 1, OP_TURN_L);
          push_ctl(ACT_START, 1);
          push_ctl(ACT_STEP, 2*w*(256/(2*w - 7) + 2));
        end
        5: begin
          load_cell(0, 0, OP_START);
          for (c = 1; c < GRID_COLS; c++) load_cell(0, c, pick_straight());
          push_ctl(ACT_START, 1);
          push_ctl(ACT_STEP, 70);
        end
        7: begin
          load_cell(0, 0, OP_START);
          load_cell(0, 1, OP_BMIRROR);
          for (r = 1; r < GRID_ROWS; r++) load_cell(r, 1, pick_straight());
          push_ctl(ACT_START, 1);
          push_ctl(ACT_STEP, 70);
        end
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            for (i = 0; i < 12; i++)
              push_req($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63),
                       $urandom_range(0, 255), $urandom_range(0, 255));
          end else begin
            h = $urandom_range(1, 4);
            w = $urandom_range(1, 8);
            for (r = 0; r < h; r++)
              for (c = 0; c < w; c++) load_cell(r, c, pick_opcode());
            if ($urandom_range(0, 3) != 0)
              load_cell($urandom_range(0, h - 1), $urandom_range(0, w - 1), OP_START);
            push_ctl(ACT_START, 1);
            n = $urandom_range(4, 30);
            for (i = 0; i < n; i++) begin
              if ($urandom_range(0, 9) == 0)
                push_req($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 255), $urandom_range(0, 255));
              else
                push_ctl(ACT_STEP, 1);
            end
          end
        end
      endcase
      if (k % 6 == 2) pending_req_q[first].hold_for_drain = 1'b1;
      k++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_req_q.size() != 0 || req_valid || expected_status_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_status_q.size() == 0)
      $display("** two_dim_tape_machine_step_core: PASSED **");
    else
      $display("** two_dim_tape_machine_step_core: FAILED **");
    $finish;
  end

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      gap_now = send_gap;
      if (req_valid && !req_stall) begin
        expected_status_q.push_back(predict_status(cur_req));
        if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
        gap_now = pick_gap(send_burst);
      end
      if (req_valid && req_stall) begin
        // hold the stalled request
      end else if (gap_now != 0) begin
        req_valid <= 1'b0;
        send_gap  <= gap_now - 1;
      end else if (pending_req_q.size() != 0 &&
                   !(pending_req_q[0].hold_for_drain && expected_status_q.size() != 0)) begin
        cur_req   <= pending_req_q.pop_front();
        req_valid <= 1'b1;
        send_gap  <= 0;
      end else begin
        req_valid <= 1'b0;
        send_gap  <= 0;
      end
    end
  end

  // Response monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      recv_hold <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        got_status = {out_valid, out_byte, halted, fault, pos_row, pos_col, heading};
        rsp_count++;
        if (expected_status_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("response %0d arrived with no request outstanding", rsp_count);
        end else begin
          want_status = expected_status_q.pop_front();
          if (got_status !== want_status) begin
            error_count++;
            if (error_count <= 10) begin
              $display("response %0d mismatch", rsp_count);
              $display("  want out_valid=%0d out_byte=%02h halted=%0d fault=%0d pos=%0d,%0d hd=%0d",
                       want_status.out_valid, want_status.out_byte, want_status.halted,
                       want_status.fault, want_status.pos_row, want_status.pos_col,
                       want_status.heading);
              $display("  got  out_valid=%0d out_byte=%02h halted=%0d fault=%0d pos=%0d,%0d hd=%0d",
                       got_status.out_valid, got_status.out_byte, got_status.halted,
                       got_status.fault, got_status.pos_row, got_status.pos_col,
                       got_status.heading);
            end
          end
        end
      end
      if (recv_hold != 0) begin
        rsp_stall <= 1'b1;
        recv_hold <= recv_hold - 1;
      end else begin
        if ($urandom_range(0, 199) == 0) recv_burst = !recv_burst;
        hold_now = pick_gap(recv_burst);
        rsp_stall <= (hold_now != 0);
        recv_hold <= (hold_now != 0) ? hold_now - 1 : 0;
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("** two_dim_tape_machine_step_core: FAILED **");
        $finish;
      end
    end
  end

endmodule
